FILE: hdl/assert_macros.svh
// assertion macros shared by the tokenizer rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/stok_pkg.sv
// types, codes and character helpers for the source tokenizer
// no dependencies
`timescale 1ns / 1ps

package stok_pkg;

    localparam int OB = 16;                     // offset counter width
    localparam int Q_DEPTH = 4;                 // request groups held between front and back
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [OB-1:0] POS_MAX = '1;

    // scanner modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NUMBER = 3'd1;
    localparam logic [2:0] MODE_IDENT  = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_OPER   = 3'd4;
    localparam logic [2:0] MODE_DONE   = 3'd5;

    // token kinds
    localparam logic [2:0] KIND_IDENT   = 3'd0;
    localparam logic [2:0] KIND_KEYWORD = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_STRING  = 3'd3;
    localparam logic [2:0] KIND_OPER    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;
    localparam logic [2:0] KIND_END     = 3'd6;

    // keyword codes
    localparam logic [1:0] KW_FALSE = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;
    localparam logic [1:0] KW_IF    = 2'd3;

    // characters with a role of their own
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       final_byte;
    } src_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [1:0]  keyword_code;
        logic        run_last;
    } tok_t;

    // all records caused by one source byte
    typedef struct packed {
        tok_t [2:0] recs;
        logic [1:0] cnt;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // { } : + - * / ( ) < > ! = , ;
    function automatic logic is_oper(input logic [7:0] b);
        return b inside {8'h7B, 8'h7D, 8'h3A, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29,
                         CH_LT, CH_GT, CH_BANG, CH_EQ, 8'h2C, 8'h3B};
    endfunction

    // operators that may take a trailing '='
    function automatic logic is_oper_pair(input logic [7:0] b);
        return b inside {CH_LT, CH_GT, CH_EQ, CH_BANG};
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] l;
        case (k)
            KW_FALSE: l = 3'd5;
            KW_TRUE:  l = 3'd4;
            KW_NULL:  l = 3'd4;
            default:  l = 3'd2;
        endcase
        return l;
    endfunction

    // letters of "false", "true", "null", "if"
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] c;
        c = CH_NUL;
        case (k)
            KW_FALSE: case (i)
                3'd0: c = 8'h66;
                3'd1: c = 8'h61;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h73;
                3'd4: c = 8'h65;
                default: c = CH_NUL;
            endcase
            KW_TRUE: case (i)
                3'd0: c = 8'h74;
                3'd1: c = 8'h72;
                3'd2: c = 8'h75;
                3'd3: c = 8'h65;
                default: c = CH_NUL;
            endcase
            KW_NULL: case (i)
                3'd0: c = 8'h6E;
                3'd1: c = 8'h75;
                3'd2: c = 8'h6C;
                3'd3: c = 8'h6C;
                default: c = CH_NUL;
            endcase
            default: case (i)
                3'd0: c = 8'h69;
                3'd1: c = 8'h66;
                default: c = CH_NUL;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [OB-1:0] pos_inc(input logic [OB-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic logic [OB-1:0] span(input logic [OB-1:0] ts, input logic [OB-1:0] e);
        return (e >= ts) ? e - ts : '0;
    endfunction

    function automatic logic [15:0] clamp16(input logic [OB-1:0] v);
        logic [OB+15:0] w;
        w = {16'd0, v};
        if (w > (OB+16)'(17'h0FFFF))
            return 16'hFFFF;
        return w[15:0];
    endfunction

    function automatic tok_t make_rec(input logic [2:0] kind, input logic [OB-1:0] start,
                                      input logic [OB-1:0] len, input logic [1:0] code);
        tok_t r;
        r.token_kind   = kind;
        r.start_offset = clamp16(start);
        r.token_length = clamp16(len);
        r.keyword_code = code;
        r.run_last     = 1'b0;
        return r;
    endfunction

    function automatic logic mode_open(input logic [2:0] m);
        return m inside {MODE_NUMBER, MODE_IDENT, MODE_STRING, MODE_OPER};
    endfunction

    // record for the token open in mode m, ending just before position e
    function automatic tok_t close_rec(input logic [2:0] m, input logic [OB-1:0] ts,
                                       input logic [3:0] kc, input logic [OB-1:0] e);
        tok_t r;
        logic [OB-1:0] len;
        logic hit;
        logic [1:0] code;
        len = span(ts, e);
        hit = 1'b0;
        code = KW_FALSE;
        for (int k = 3; k >= 0; k--) begin
            if (kc[k] && len == OB'(kw_len(2'(k)))) begin
                hit = 1'b1;
                code = 2'(k);
            end
        end
        case (m)
            MODE_NUMBER: r = make_rec(KIND_NUMBER, ts, len, KW_FALSE);
            MODE_IDENT:  r = hit ? make_rec(KIND_KEYWORD, ts, len, code)
                                 : make_rec(KIND_IDENT, ts, len, KW_FALSE);
            MODE_STRING: r = make_rec(KIND_STRING, ts, len, KW_FALSE);
            default:     r = make_rec(KIND_OPER, ts, OB'(1), KW_FALSE);
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/stok_front.sv
// scanner front end: takes one source byte per cycle unless the queue is full,
// keeps the scan state, writes that byte's records as one group; uses stok_pkg
`timescale 1ns / 1ps

module stok_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  stok_pkg::src_t    src,
    input  stok_pkg::q_stat_t q_stat,
    output logic              push,
    output stok_pkg::grp_t    push_grp
);
    import stok_pkg::*;

    logic [2:0]    mode_reg, mode_next;
    logic          qs_reg, qs_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] ts_reg, ts_next;
    logic [3:0]    kc_reg, kc_next;

    logic          accept;
    logic [7:0]    b;
    logic [OB-1:0] p;
    logic [OB-1:0] idx;
    logic          fresh;
    logic [1:0]    n_v;
    tok_t [2:0]    recs_v;

    assign src_stall = q_stat.full;
    assign accept    = src_valid && !q_stat.full;

    always_comb
    begin
        mode_next = mode_reg;
        qs_next   = qs_reg;
        ts_next   = ts_reg;
        kc_next   = kc_reg;
        b         = src.source_byte;
        p         = pos_reg;
        idx       = span(ts_reg, pos_reg);
        fresh     = 1'b0;
        n_v       = 2'd0;
        recs_v    = '0;

        // continue or close the open token
        case (mode_reg)
            MODE_NUMBER:
                if (!is_digit(b))
                    fresh = 1'b1;
            MODE_IDENT:
                if (is_digit(b) || is_alpha(b))
                begin
                    for (int k = 0; k < 4; k++)
                        if (idx >= OB'(kw_len(2'(k))) || kw_char(2'(k), idx[2:0]) != b)
                            kc_next[k] = 1'b0;
                end
                else
                    fresh = 1'b1;
            MODE_STRING:
                if (b == CH_NUL)
                    fresh = 1'b1;
                else if (b == (qs_reg ? CH_SQUOTE : CH_DQUOTE))
                begin
                    recs_v[n_v] = close_rec(mode_reg, ts_reg, kc_reg, p);
                    n_v = n_v + 2'd1;
                    mode_next = MODE_IDLE;
                end
            MODE_OPER:
                if (b == CH_EQ)
                begin
                    recs_v[n_v] = make_rec(KIND_OPER, ts_reg, OB'(2), KW_FALSE);
                    n_v = n_v + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                    fresh = 1'b1;
            MODE_DONE:
                fresh = 1'b0;
            default:
                fresh = 1'b1;
        endcase

        // a byte that cannot extend the token closes it and is scanned afresh
        if (fresh && mode_open(mode_reg))
        begin
            recs_v[n_v] = close_rec(mode_reg, ts_reg, kc_reg, p);
            n_v = n_v + 2'd1;
            mode_next = MODE_IDLE;
        end

        if (fresh && !is_space(b))
        begin
            if (b == CH_NUL)
            begin
                recs_v[n_v] = make_rec(KIND_END, p, '0, KW_FALSE);
                n_v = n_v + 2'd1;
                mode_next = MODE_DONE;
            end
            else if (is_oper(b))
            begin
                if (is_oper_pair(b))
                begin
                    mode_next = MODE_OPER;
                    ts_next = p;
                end
                else
                begin
                    recs_v[n_v] = make_rec(KIND_OPER, p, OB'(1), KW_FALSE);
                    n_v = n_v + 2'd1;
                end
            end
            else if (b == CH_DQUOTE || b == CH_SQUOTE)
            begin
                mode_next = MODE_STRING;
                qs_next = (b == CH_SQUOTE);
                ts_next = pos_inc(p);
            end
            else if (is_digit(b))
            begin
                mode_next = MODE_NUMBER;
                ts_next = p;
            end
            else if (is_alpha(b))
            begin
                mode_next = MODE_IDENT;
                ts_next = p;
                for (int k = 0; k < 4; k++)
                    kc_next[k] = (kw_char(2'(k), 3'd0) == b);
            end
            else
            begin
                recs_v[n_v] = make_rec(KIND_ERROR, p, OB'(1), KW_FALSE);
                n_v = n_v + 2'd1;
                mode_next = MODE_DONE;
            end
        end

        pos_next = pos_inc(p);

        // final_byte: unless done, flush open token, add end record; restart
        if (src.final_byte)
        begin
            if (mode_next != MODE_DONE)
            begin
                if (mode_open(mode_next) && n_v != 2'd3)
                begin
                    recs_v[n_v] = close_rec(mode_next, ts_next, kc_next, pos_next);
                    n_v = n_v + 2'd1;
                end
                if (n_v != 2'd3)
                begin
                    recs_v[n_v] = make_rec(KIND_END, pos_next, '0, KW_FALSE);
                    n_v = n_v + 2'd1;
                end
            end
            mode_next = MODE_IDLE;
            qs_next   = 1'b0;
            pos_next  = '0;
            ts_next   = '0;
            kc_next   = 4'hF;
        end

        if (n_v != 2'd0)
            recs_v[n_v - 2'd1].run_last = 1'b1;
    end

    assign push          = accept && (n_v != 2'd0);
    assign push_grp.recs = recs_v;
    assign push_grp.cnt  = n_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            qs_reg   <= 1'b0;
            pos_reg  <= '0;
            ts_reg   <= '0;
            kc_reg   <= 4'hF;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            qs_reg   <= qs_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            kc_reg   <= kc_next;
        end
    end

endmodule

FILE: hdl/stok_queue.sv
// short queue of record groups between the scanner and the output side
// uses stok_pkg
`timescale 1ns / 1ps

module stok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stok_pkg::grp_t    push_grp,
    input  logic              pop,
    output stok_pkg::grp_t    head,
    output stok_pkg::q_stat_t q_stat
);
    import stok_pkg::*;

    grp_t               ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign q_stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head         = ent_reg[rd_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hdl/stok_back.sv
// output side: walks the records of the head group one per cycle, unless tok
// stalls, into an output register; uses stok_pkg
`timescale 1ns / 1ps

module stok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  stok_pkg::q_stat_t q_stat,
    input  stok_pkg::grp_t    head,
    output logic              pop,
    output logic              tok_valid,
    input  logic              tok_stall,
    output stok_pkg::tok_t    tok
);
    import stok_pkg::*;

    logic       valid_reg, valid_next;
    tok_t       tok_reg, tok_next;
    logic [1:0] sel_reg, sel_next;
    logic       load;
    logic       last_in_grp;

    // output register is free when empty or being taken this cycle
    assign load        = (!valid_reg || !tok_stall) && !q_stat.empty;
    assign last_in_grp = (sel_reg == head.cnt - 2'd1);
    assign pop         = load && last_in_grp;

    always_comb
    begin
        valid_next = valid_reg;
        tok_next   = tok_reg;
        sel_next   = sel_reg;
        if (!valid_reg || !tok_stall)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            tok_next   = head.recs[sel_reg];
            sel_next   = last_in_grp ? 2'd0 : sel_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

FILE: hdl/source_tokenizer.sv
// source tokenizer top level: scanner front, group queue and output side
// uses stok_pkg, stok_front, stok_queue, stok_back and assert_macros.svh
//
// usage
//   src channel: one source byte per request (source_byte, final_byte). a zero
//   byte ends the source; final_byte marks the last byte and restarts the
//   scanner at position 0 for the next source.
//   tok channel: one token record per request (kind, start offset, length,
//   keyword code, run_last on the last record caused by a byte).
//   a record passes from the scanner through the queue into the output
//   register; a byte may cause zero to three records.
//   throughput: one byte per cycle in while the queue is not full, one
//   record per cycle out while tok is not stalled; the four-group queue
//   between scanner and output register absorbs bursts of records.
//   src_stall rises only when the queue is full, so a stall on tok backs up
//   into the queue first and then into the source.
//   reset: scanner idle at position 0, queue empty, no record valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module source_tokenizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  stok_pkg::src_t src,
    output logic           tok_valid,
    input  logic           tok_stall,
    output stok_pkg::tok_t tok
);
    import stok_pkg::*;

    q_stat_t q_stat;
    grp_t    push_grp;
    grp_t    head;
    logic    push;
    logic    pop;

    stok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src       (src),
        .q_stat    (q_stat),
        .push      (push),
        .push_grp  (push_grp)
    );

    stok_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    stok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

    // end and error records always close the run of their byte
    `ST_ASSERT_IMP(a_end_last, tok_valid && tok.token_kind == KIND_END, tok.run_last, "end record not last")
    `ST_ASSERT_IMP(a_err_shape, tok_valid && tok.token_kind == KIND_ERROR, tok.run_last && tok.token_length == 16'd1, "bad error record")
    // keyword length must match its code
    `ST_ASSERT_IMP(a_kw_len, tok_valid && tok.token_kind == KIND_KEYWORD, (tok.keyword_code == KW_FALSE && tok.token_length == 16'd5) || (tok.keyword_code == KW_TRUE && tok.token_length == 16'd4) || (tok.keyword_code == KW_NULL && tok.token_length == 16'd4) || (tok.keyword_code == KW_IF && tok.token_length == 16'd2), "keyword length mismatch")
    // a waiting group is picked up by a free output register
    `ST_ASSERT_NEXT(a_drain, !q_stat.empty && !tok_valid, tok_valid, "queue not drained")

endmodule
